// ===== rtl/core/dfps_pkg.sv =====
package dfps_pkg;

  localparam int unsigned PixelW   = 24;
  localparam int unsigned WholeW   = 7;
  localparam int unsigned TenthsW  = 4;
  localparam int unsigned WidthW   = 13;
  localparam int unsigned ColumnW  = 12;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned CopiesW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned MarkW    = 10;

  localparam logic [WidthW-1:0]  MaxWidth   = WidthW'(4096);
  localparam logic [WholeW-1:0]  MaxWhole   = WholeW'(100);
  localparam logic [TenthsW-1:0] MaxTenths  = TenthsW'(9);
  localparam logic [PhaseW-1:0]  FirstPhase = PhaseW'(1);
  localparam logic [PhaseW-1:0]  LastPhase  = PhaseW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHOLE_FACTOR = 2'd0,
    CFG_TENTHS_DIGIT = 2'd1,
    CFG_SOURCE_WIDTH = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  // Position information handed from the raster tracker to the result logic.
  typedef struct packed {
    logic              last;
    logic [PhaseW-1:0] column_phase;
    logic [PhaseW-1:0] row_phase;
  } raster_pos_t;

  // Bit p-1 set: position p gets one extra copy for that tenths digit.
  function automatic logic [MarkW-1:0] mark_row(input logic [TenthsW-1:0] digit);
    logic [MarkW-1:0] m;
    case (digit)
      4'd1:    m = 10'h010;
      4'd2:    m = 10'h084;
      4'd3:    m = 10'h112;
      4'd4:    m = 10'h14A;
      4'd5:    m = 10'h155;
      4'd6:    m = 10'h2B5;
      4'd7:    m = 10'h2DD;
      4'd8:    m = 10'h37B;
      4'd9:    m = 10'h3DF;
      default: m = 10'h000;
    endcase
    return m;
  endfunction

  function automatic logic [CopiesW-1:0] copies_at(input logic [WholeW-1:0] whole,
                                                   input logic [TenthsW-1:0] tenths,
                                                   input logic [PhaseW-1:0] phase);
    logic [WholeW-1:0] w;
    logic [MarkW-1:0]  m;
    logic              extra;
    w = (whole > MaxWhole) ? MaxWhole : whole;
    m = mark_row(tenths);
    extra = 1'b0;
    if (phase >= FirstPhase && phase <= LastPhase) begin
      extra = m[phase - FirstPhase];
    end
    return CopiesW'(w) + CopiesW'(extra);
  endfunction

endpackage

// ===== rtl/core/dfps_raster_pos.sv =====
module dfps_raster_pos (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [dfps_pkg::WidthW-1:0] source_width,
  output dfps_pkg::raster_pos_t       pos
);

  logic [dfps_pkg::ColumnW-1:0] column_index_r, column_index_nxt;
  logic [dfps_pkg::PhaseW-1:0]  column_phase_r, column_phase_nxt;
  logic [dfps_pkg::PhaseW-1:0]  row_phase_r, row_phase_nxt;
  logic [dfps_pkg::WidthW-1:0]  eff_width;
  logic                         last;

  always_comb begin
    eff_width = source_width;
    if (eff_width == '0) begin
      eff_width = dfps_pkg::WidthW'(1);
    end
    if (eff_width > dfps_pkg::MaxWidth) begin
      eff_width = dfps_pkg::MaxWidth;
    end
  end

  // The row ends once the next column would reach the width, which also
  // covers a width shrunk part way through a row.
  assign last = ({1'b0, column_index_r} + dfps_pkg::WidthW'(1)) >= eff_width;

  always_comb begin
    column_index_nxt = column_index_r;
    column_phase_nxt = column_phase_r;
    row_phase_nxt    = row_phase_r;
    if (advance) begin
      if (last) begin
        column_index_nxt = '0;
        column_phase_nxt = dfps_pkg::FirstPhase;
        row_phase_nxt    = (row_phase_r >= dfps_pkg::LastPhase) ? dfps_pkg::FirstPhase
                                                                 : row_phase_r + 1'b1;
      end else begin
        column_index_nxt = column_index_r + 1'b1;
        column_phase_nxt = (column_phase_r >= dfps_pkg::LastPhase) ? dfps_pkg::FirstPhase
                                                                   : column_phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r <= '0;
      column_phase_r <= dfps_pkg::FirstPhase;
      row_phase_r    <= dfps_pkg::FirstPhase;
    end else begin
      column_index_r <= column_index_nxt;
      column_phase_r <= column_phase_nxt;
      row_phase_r    <= row_phase_nxt;
    end
  end

  assign pos.last         = last;
  assign pos.column_phase = column_phase_r;
  assign pos.row_phase    = row_phase_r;

endmodule

// ===== rtl/core/decimal_factor_pixel_scaler_core.sv =====
// Pixel scaler core: takes one source pixel per clock unless stalled, in raster
// order, and returns in the next cycle the pixel with its horizontal copy count and,
// on the last pixel of a row, the copy count for that row. One result follows every
// input beat. A single output register holds the result, so a new pixel is taken
// in every cycle in which that register is empty or its result is being taken;
// the rate is one pixel per clock unless stalled. The column, column phase and row
// phase counters advance on each accepted pixel; configuration writes apply from
// the next pixel on; they should be made only while no result is outstanding.
module decimal_factor_pixel_scaler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dfps_pkg::PixelW-1:0]   in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dfps_pkg::PixelW-1:0]   out_pixel_out,
  output logic [dfps_pkg::CopiesW-1:0]  out_column_copies,
  output logic                          out_row_end,
  output logic [dfps_pkg::CopiesW-1:0]  out_row_copies,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dfps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dfps_pkg::CfgDataW-1:0] cfg_data
);

  logic [dfps_pkg::WholeW-1:0]  whole_factor_r;
  logic [dfps_pkg::TenthsW-1:0] tenths_digit_r;
  logic [dfps_pkg::WidthW-1:0]  source_width_r;
  logic [dfps_pkg::TenthsW-1:0] eff_tenths;

  logic                         accept;
  dfps_pkg::raster_pos_t        pos;

  logic                         out_valid_r, out_valid_nxt;
  logic [dfps_pkg::PixelW-1:0]  pixel_r;
  logic [dfps_pkg::CopiesW-1:0] column_copies_r, column_copies_nxt;
  logic                         row_end_r;
  logic [dfps_pkg::CopiesW-1:0] row_copies_r, row_copies_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_factor_r <= dfps_pkg::WholeW'(1);
      tenths_digit_r <= '0;
      source_width_r <= dfps_pkg::WidthW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (dfps_pkg::cfg_idx_t'(cfg_index))
        dfps_pkg::CFG_WHOLE_FACTOR: whole_factor_r <= cfg_data[dfps_pkg::WholeW-1:0];
        dfps_pkg::CFG_TENTHS_DIGIT: tenths_digit_r <= cfg_data[dfps_pkg::TenthsW-1:0];
        dfps_pkg::CFG_SOURCE_WIDTH: source_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  dfps_raster_pos u_raster_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .source_width (source_width_r),
    .pos          (pos)
  );

  assign eff_tenths = (tenths_digit_r > dfps_pkg::MaxTenths) ? '0 : tenths_digit_r;

  always_comb begin
    column_copies_nxt = dfps_pkg::copies_at(whole_factor_r, eff_tenths, pos.column_phase);
    row_copies_nxt    = '0;
    if (pos.last) begin
      row_copies_nxt = dfps_pkg::copies_at(whole_factor_r, eff_tenths, pos.row_phase);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_r         <= in_pixel_in;
      column_copies_r <= column_copies_nxt;
      row_end_r       <= pos.last;
      row_copies_r    <= row_copies_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = pixel_r;
  assign out_column_copies = column_copies_r;
  assign out_row_end       = row_end_r;
  assign out_row_copies    = row_copies_r;

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import dfps_pkg::*;

  typedef struct packed {
    logic [PixelW-1:0]  pixel;
    logic [CopiesW-1:0] col_copies;
    logic               row_end;
    logic [CopiesW-1:0] row_copies;
  } scaled_pixel_t;

  typedef enum logic {
    ROW_PIXEL,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    cfg_idx_t            idx;
    logic [CfgDataW-1:0] data;
    logic [PixelW-1:0]   pixel;
    logic                typed;
    scaled_pixel_t       want;
  } stim_row_t;

  // Ten marks per tenths digit; digit d occupies bits [d*10 +: 10], position p is bit p-1.
  localparam logic [99:0] MARK_BITS = {10'h3DF, 10'h37B, 10'h2DD, 10'h2B5, 10'h155,
                                       10'h14A, 10'h112, 10'h084, 10'h010, 10'h000};
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 50;
  localparam int RANDOM_PIXELS  = 800;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PixelW-1:0]   in_pixel_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PixelW-1:0]   out_pixel_out;
  logic [CopiesW-1:0]  out_column_copies;
  logic                out_row_end;
  logic [CopiesW-1:0]  out_row_copies;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Scaler state as the predictor sees it.
  logic [WholeW-1:0]  whole_q = 7'd1;
  logic [TenthsW-1:0] tenths_q = 4'd0;
  logic [WidthW-1:0]  width_q = 13'd1;
  int                 col_idx = 0;
  logic [PhaseW-1:0]  col_phase = 4'd1;
  logic [PhaseW-1:0]  row_phase = 4'd1;

  scaled_pixel_t copies_due[$];
  stim_row_t     stim_rows[$];
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_req = 1'b0;
  int            quiet_cycles = 0;

  decimal_factor_pixel_scaler_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel_in       (in_pixel_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_out     (out_pixel_out),
    .out_column_copies (out_column_copies),
    .out_row_end       (out_row_end),
    .out_row_copies    (out_row_copies),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CopiesW-1:0] copies_for(input logic [PhaseW-1:0] phase);
    int w;
    int t;
    w = (whole_q > 7'd100) ? 100 : int'(whole_q);
    t = (tenths_q > 4'd9) ? 0 : int'(tenths_q);
    if (t != 0) begin
      w = w + int'(MARK_BITS[t * 10 + int'(phase) - 1]);
    end
    return CopiesW'(w);
  endfunction

  task automatic predict_scaled(input logic [PixelW-1:0] pix, output scaled_pixel_t r);
    int   wd;
    logic last_px;
    wd = (width_q == '0) ? 1 : ((width_q > 13'd4096) ? 4096 : int'(width_q));
    last_px = (col_idx + 1) >= wd;
    r.pixel = pix;
    r.col_copies = copies_for(col_phase);
    r.row_end = last_px;
    r.row_copies = last_px ? copies_for(row_phase) : '0;
    if (last_px) begin
      col_idx = 0;
      col_phase = 4'd1;
      row_phase = (row_phase >= 4'd10) ? 4'd1 : row_phase + 4'd1;
    end else begin
      col_idx = col_idx + 1;
      col_phase = (col_phase >= 4'd10) ? 4'd1 : col_phase + 4'd1;
    end
  endtask

  task automatic add_pixel(input logic [PixelW-1:0] pix, input logic typed,
                           input scaled_pixel_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.pixel = pix;
    r.typed = typed;
    r.want = want;
    stim_rows.push_back(r);
  endtask

  task automatic add_write(input cfg_idx_t idx, input logic [CfgDataW-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    stim_rows.push_back(r);
  endtask

  // Registers change only once every outstanding result has been taken.
  task automatic wait_idle();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (copies_due.size() != 0) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; the next pixel beat lowers it.
  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WHOLE_FACTOR: whole_q = data[WholeW-1:0];
      CFG_TENTHS_DIGIT: tenths_q = data[TenthsW-1:0];
      CFG_SOURCE_WIDTH: width_q = data[WidthW-1:0];
      default: ;
    endcase
  endtask

  task automatic offer_pixel(input logic [PixelW-1:0] pix, input logic typed,
                             input scaled_pixel_t want);
    scaled_pixel_t p;
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    predict_scaled(pix, p);
    copies_due.push_back(typed ? want : p);
  endtask

  // Receiver: random stalls, or a long hold-off when asked for one.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    scaled_pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (copies_due.size() == 0) begin
        $error("unexpected result beat: pixel_out %h", out_pixel_out);
        mismatches++;
      end else begin
        e = copies_due.pop_front();
        if (out_pixel_out !== e.pixel) begin
          $error("pixel_out: expected %h, got %h", e.pixel, out_pixel_out);
          mismatches++;
        end
        if (out_column_copies !== e.col_copies) begin
          $error("column_copies: expected %0d, got %0d", e.col_copies, out_column_copies);
          mismatches++;
        end
        if (out_row_end !== e.row_end) begin
          $error("row_end: expected %0d, got %0d", e.row_end, out_row_end);
          mismatches++;
        end
        if (out_row_copies !== e.row_copies) begin
          $error("row_copies: expected %0d, got %0d", e.row_copies, out_row_copies);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int                  seg;
    int                  sent;
    int                  n;
    logic [CfgDataW-1:0] val;
    stim_row_t           r;

    // After reset the factor is 1.0 and every pixel is a row of its own.
    add_pixel(24'h000000, 1'b1, '{24'h000000, 7'd1, 1'b1, 7'd1});
    add_pixel(24'hFFFFFF, 1'b1, '{24'hFFFFFF, 7'd1, 1'b1, 7'd1});
    add_write(CFG_WHOLE_FACTOR, 13'd0);
    add_pixel(24'hA5A5A5, 1'b1, '{24'hA5A5A5, 7'd0, 1'b1, 7'd0});
    // Whole part above the ceiling is clamped; upper data bits are not stored.
    add_write(CFG_WHOLE_FACTOR, 13'h1FFF);
    add_pixel(24'h5A5A5A, 1'b1, '{24'h5A5A5A, 7'd100, 1'b1, 7'd100});
    // A tenths digit beyond nine counts as no fraction at all.
    add_write(CFG_TENTHS_DIGIT, 13'h1FFF);
    add_pixel(24'h123456, 1'b1, '{24'h123456, 7'd100, 1'b1, 7'd100});
    add_write(CFG_TENTHS_DIGIT, 13'd9);
    add_pixel(24'h800001, 1'b0, '0);
    add_write(CFG_WHOLE_FACTOR, 13'd2);
    add_write(CFG_TENTHS_DIGIT, 13'd5);
    add_write(CFG_SOURCE_WIDTH, 13'd5);
    add_pixel(24'h010203, 1'b0, '0);
    add_pixel(24'h040506, 1'b0, '0);
    add_pixel(24'h070809, 1'b0, '0);
    // Shrinking the width mid-row ends the row on the next pixel.
    add_write(CFG_SOURCE_WIDTH, 13'd2);
    add_pixel(24'h0A0B0C, 1'b0, '0);
    add_write(CFG_SOURCE_WIDTH, 13'd0);
    add_pixel(24'h0D0E0F, 1'b0, '0);
    add_write(CFG_UNUSED, 13'h1FFF);
    add_pixel(24'h7FFFFF, 1'b0, '0);
    add_write(CFG_WHOLE_FACTOR, 13'd100);
    add_write(CFG_SOURCE_WIDTH, 13'h1FFF);
    add_pixel(24'hFEDCBA, 1'b0, '0);
    add_pixel(24'h000001, 1'b0, '0);
    add_pixel(24'hFFFFFE, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      if (r.kind == ROW_WRITE) begin
        wait_idle();
        write_reg(r.idx, r.data);
      end else begin
        offer_pixel(r.pixel, r.typed, r.want);
      end
    end

    seg = 0;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if (sent < RANDOM_PIXELS / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 66;
      end else if (sent < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(5) == 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(5))
          0: val = 13'd0;
          1: val = 13'd100;
          2: val = 13'($urandom_range(101, 127));
          3: val = 13'($urandom_range(0, 8191));
          default: val = 13'($urandom_range(1, 4));
        endcase
        write_reg(CFG_WHOLE_FACTOR, val);
      end
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(5))
          0: val = 13'd0;
          1: val = 13'($urandom_range(10, 15));
          2: val = 13'($urandom_range(0, 8191));
          default: val = 13'($urandom_range(1, 9));
        endcase
        write_reg(CFG_TENTHS_DIGIT, val);
      end
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(7))
          0: val = 13'd0;
          1: val = 13'd4096;
          2: val = 13'($urandom_range(4097, 8191));
          3: val = 13'($urandom_range(10, 40));
          default: val = 13'($urandom_range(1, 12));
        endcase
        write_reg(CFG_SOURCE_WIDTH, val);
      end
      if ($urandom_range(7) == 0) begin
        write_reg(CFG_UNUSED, 13'($urandom_range(0, 8191)));
      end
      // One segment keeps the sender busy while the sink holds off, so the core backs up.
      if (seg == 1) begin
        send_idle_pct = 0;
        hold_req = 1'b1;
      end
      n = $urandom_range(10, 60);
      repeat (n) begin
        offer_pixel(24'($urandom()), 1'b0, '0);
        sent++;
      end
      seg++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dfps_pkg.sv
rtl/core/dfps_raster_pos.sv
rtl/core/decimal_factor_pixel_scaler_core.sv
verif/testbench.sv
